// ===== hdl/psf_pkg.sv =====
`default_nettype none
package psf_pkg;

	typedef enum logic [3:0] {
		PH_MAGIC    = 4'd0,
		PH_VERSION  = 4'd1,
		PH_RESERVED = 4'd2,
		PH_PROGRAM  = 4'd3,
		PH_SKIP     = 4'd4,
		PH_MARK     = 4'd5,
		PH_MARK_BAD = 4'd6,
		PH_BODY     = 4'd7,
		PH_DRAIN    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_PSF   = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_BAD_TAG   = 2'd3
	} status_t;

	localparam int SkipWidth = 34;
	localparam logic [SkipWidth-1:0] SkipBase = SkipWidth'(4);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic       is_status;
		logic [7:0] tag_byte;
		status_t    status;
	} parse_out_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h50;
			2'd1:    b = 8'h53;
			default: b = 8'h46;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] marker_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h5B;
			3'd1:    b = 8'h54;
			3'd2:    b = 8'h41;
			3'd3:    b = 8'h47;
			default: b = 8'h5D;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/psf_if.sv =====
`default_nettype none
interface psf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface psf_out_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] tag_byte;
	logic [1:0] status;

	modport source (output valid, output is_status, output tag_byte, output status,
		input ready);
	modport sink (input valid, input is_status, input tag_byte, input status,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/psf_parser.sv =====
`default_nettype none
module psf_parser
	import psf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire item_t      item,
	output parse_out_t      res
);

	phase_t                 phase_q, phase_d;
	logic [2:0]             pos_q, pos_d;
	logic [31:0]            size_q, size_d;
	logic [SkipWidth-1:0]   skip_q, skip_d;
	logic                   err_q, err_d;

	logic [7:0]             b;
	logic [31:0]            size_full;
	logic [SkipWidth-1:0]   skip_dec;
	logic [2:0]             mark_pos;
	logic                   mark_bad;
	logic                   magic_bad;

	assign b         = item.data_byte;
	assign size_full = {b, size_q[23:0]};
	assign skip_dec  = skip_q - SkipWidth'(skip_q != '0);
	assign mark_pos  = (pos_q > 3'd4) ? 3'd4 : pos_q;
	assign mark_bad  = (phase_q == PH_MARK_BAD) || (b != marker_byte(mark_pos));
	assign magic_bad = (pos_q > 3'd2) || (b != magic_byte(pos_q[1:0]));

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		size_d  = size_q;
		skip_d  = skip_q;
		err_d   = err_q;
		if (item.end_of_stream) begin
			phase_d = PH_MAGIC;
			pos_d   = '0;
			size_d  = '0;
			skip_d  = '0;
			err_d   = 1'b0;
		end else begin
			case (phase_q)
				PH_MAGIC: begin
					if (magic_bad) begin
						phase_d = PH_DRAIN;
						err_d   = 1'b1;
					end else if (pos_q == 3'd2) begin
						phase_d = PH_VERSION;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
				PH_VERSION: begin
					phase_d = PH_RESERVED;
					pos_d   = '0;
					size_d  = '0;
				end
				PH_RESERVED, PH_PROGRAM: begin
					// little-endian byte lanes
					case (pos_q[1:0])
						2'd0:    size_d[7:0]   = b;
						2'd1:    size_d[15:8]  = b;
						2'd2:    size_d[23:16] = b;
						default: size_d[31:24] = b;
					endcase
					if (pos_q[1:0] == 2'd3) begin
						if (phase_q == PH_RESERVED) begin
							skip_d  = SkipBase + SkipWidth'(size_full);
							phase_d = PH_PROGRAM;
						end else begin
							skip_d  = skip_q + SkipWidth'(size_full);
							phase_d = PH_SKIP;
						end
						size_d = '0;
						pos_d  = '0;
					end else begin
						pos_d = {1'b0, pos_q[1:0]} + 3'd1;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = PH_MARK;
						pos_d   = '0;
					end
				end
				PH_MARK, PH_MARK_BAD: begin
					if (mark_bad) phase_d = PH_MARK_BAD;
					if (mark_pos == 3'd4) begin
						pos_d = '0;
						if (mark_bad) begin
							phase_d = PH_DRAIN;
							err_d   = 1'b1;
						end else begin
							phase_d = PH_BODY;
						end
					end else begin
						pos_d = mark_pos + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result of the current item
	always_comb begin
		res = '{valid: 1'b0, is_status: 1'b0, tag_byte: 8'h00, status: ST_OK};
		if (item.end_of_stream) begin
			res.is_status = 1'b1;
			case (phase_q)
				PH_MAGIC: begin
					res.valid  = !err_q;
					res.status = ST_NOT_PSF;
				end
				PH_VERSION, PH_RESERVED, PH_PROGRAM: begin
					res.valid  = !err_q;
					res.status = ST_TRUNCATED;
				end
				PH_SKIP, PH_MARK, PH_MARK_BAD, PH_BODY: begin
					res.valid = !err_q;
				end
				default: begin
				end
			endcase
		end else begin
			case (phase_q)
				PH_MAGIC: begin
					if (magic_bad) begin
						res.valid     = 1'b1;
						res.is_status = 1'b1;
						res.status    = ST_NOT_PSF;
					end
				end
				PH_MARK, PH_MARK_BAD: begin
					if (mark_pos == 3'd4 && mark_bad) begin
						res.valid     = 1'b1;
						res.is_status = 1'b1;
						res.status    = ST_BAD_TAG;
					end
				end
				PH_BODY: begin
					res.valid    = 1'b1;
					res.tag_byte = b;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			pos_q   <= '0;
			size_q  <= '0;
			skip_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			size_q  <= size_d;
			skip_q  <= skip_d;
			err_q   <= err_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/psf_tag_extractor.sv =====
// Streaming PSF tag extractor. Feed the file one byte per item on stream and close it
// with an item that has end_of_stream set; the parser then restarts for the next file.
// Each tag byte after the [TAG] marker comes out as a result with is_status low, and
// every stream ends with one status result (0 success, 1 not PSF, 2 truncated header,
// 3 bad tag marker), except that after an error status the rest of that stream,
// its end included, gives no further result. A byte is taken every clock cycle unless
// the input is stalled; an item goes through an input register and the parser logic
// into the result register, from which its result is offered. result.ready low only
// stalls the input once both registers hold items.
`default_nettype none
module psf_tag_extractor
	import psf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	psf_in_if.sink     stream,
	psf_out_if.source  result
);

	logic       valid_s1;
	item_t      item_s1;
	logic       advance;
	parse_out_t step_res;

	logic       res_valid_q;
	logic       is_status_q;
	logic [7:0] tag_byte_q;
	status_t    status_q;

	// the item in the input register moves on once the result register is free
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			item_s1 <= '{data_byte: stream.data_byte, end_of_stream: stream.end_of_stream};
		end
	end

	psf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step_res.valid;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			is_status_q <= step_res.is_status;
			tag_byte_q  <= step_res.tag_byte;
			status_q    <= step_res.status;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.is_status = is_status_q;
	assign result.tag_byte  = tag_byte_q;
	assign result.status    = status_q;

endmodule
`default_nettype wire
